>>> rtl/plst_pkg.sv
// plst_pkg: shared types and constants of the positional list store
// command codes, sequencer states, field widths and parameter defaults
// no dependencies
package plst_pkg;

  // field widths of the channels
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int IDX_W = 7;
  localparam int CAP_W = 7;

  // parameter defaults
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // capacity limit after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // found index when no entry matches
  localparam logic [IDX_W-1:0] FOUND_NONE = '1;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_READ   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_ERASE,
    S_READ,
    S_FIND,
    S_FINISH
  } state_t;

endpackage

>>> rtl/plst_ifs.sv
// plst_ifs: valid/ready channel interfaces of the positional list store
// command channel, response channel and capacity write channel
// depends on plst_pkg
interface plst_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::CMD_W-1:0]   cmd;
  logic [plst_pkg::POS_W-1:0]   position;
  logic [plst_pkg::VAL_W-1:0]   value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface plst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [plst_pkg::VAL_W-1:0]   read_value;
  logic signed [plst_pkg::IDX_W-1:0] found_index;
  logic [plst_pkg::CNT_W-1:0]   entry_count;
  logic                         empty_flag;
  logic                         full_flag;

  modport source (output valid, ok, read_value, found_index, entry_count,
                  empty_flag, full_flag, input ready);
  modport sink   (input valid, ok, read_value, found_index, entry_count,
                  empty_flag, full_flag, output ready);
endinterface

interface plst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::CAP_W-1:0]   capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

>>> rtl/positional_list_store.sv
// positional_list_store: ordered list of data words kept in one memory with a count
// a small sequencer walks the memory through one read port and one write port
// depends on plst_pkg and the interfaces in plst_ifs
//
//   channel  role    transfer moves
//   -------  ------  -------------------------------------------------
//   req      sink    cmd, position, value
//   rsp      source  ok, read_value, found_index, entry_count, flags
//   cfg      sink    capacity_limit (always ready)
//
// shifts and searches move one entry a cycle
// req is ready only while the sequencer is idle; a result waiting on rsp does not
// block the next command, but a finished command waits for rsp to drain
// reset clears count and control state and sets capacity to CAP_RESET; memory contents are not cleared
module positional_list_store #(
  parameter int DEPTH      = plst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  plst_cmd_if.sink          req,
  plst_rsp_if.source        rsp,
  plst_cfg_if.sink          cfg
);

  localparam int CW      = plst_pkg::CNT_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = (AW > CW) ? AW : CW;
  localparam int XW      = (DATA_WIDTH > plst_pkg::VAL_W) ? DATA_WIDTH : plst_pkg::VAL_W;
  localparam int LIM_MAX = (DEPTH < 127) ? DEPTH : 127;
  localparam logic [CW-1:0] LIM_C = CW'(LIM_MAX);

  // list index to memory address
  function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] x);
    logic [IW-1:0] t;
    t = IW'(x);
    return t[AW-1:0];
  endfunction

  plst_pkg::state_t state, state_next;

  logic [CW-1:0]          count, count_next;
  logic [plst_pkg::CAP_W-1:0] cap;
  logic [CW-1:0]          eff_lim;
  logic [CW-1:0]          ptr, ptr_next;
  logic                   pend, pend_next;
  logic [CW-1:0]          pend_addr, pend_addr_next;
  logic [CW-1:0]          pos_q, pos_next;
  logic [DATA_WIDTH-1:0]  val_q, val_next;
  logic                   ok_q, ok_next;
  logic [plst_pkg::VAL_W-1:0] rd_q, rd_next;
  logic [plst_pkg::IDX_W-1:0] found_q, found_next;

  logic                   req_fire;
  logic                   rsp_load;
  logic [XW-1:0]          val_ext;
  logic [XW-1:0]          rdata_ext;

  // memory port signals
  logic [DATA_WIDTH-1:0]  mem [DEPTH];
  logic [DATA_WIDTH-1:0]  rdata;
  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_ra, mem_wa;
  logic [DATA_WIDTH-1:0]  mem_wd;

  assign req.ready = (state == plst_pkg::S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign eff_lim   = (cap > LIM_C) ? LIM_C : cap;
  assign val_ext   = XW'(req.value);
  assign rdata_ext = XW'(rdata);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plst_pkg::S_IDLE: begin
        if (req_fire) begin
          case (req.cmd)
            plst_pkg::CMD_INSERT: begin
              if (count < eff_lim && req.position <= count) begin
                state_next = plst_pkg::S_INSERT;
              end else begin
                state_next = plst_pkg::S_FINISH;
              end
            end
            plst_pkg::CMD_ERASE: begin
              state_next = (req.position < count) ? plst_pkg::S_ERASE : plst_pkg::S_FINISH;
            end
            plst_pkg::CMD_READ: begin
              state_next = (req.position < count) ? plst_pkg::S_READ : plst_pkg::S_FINISH;
            end
            plst_pkg::CMD_FIND: state_next = plst_pkg::S_FIND;
            default:            state_next = plst_pkg::S_FINISH;
          endcase
        end
      end
      plst_pkg::S_INSERT: begin
        if (!(ptr > pos_q) && !pend) state_next = plst_pkg::S_FINISH;
      end
      plst_pkg::S_ERASE: begin
        if (!(ptr < count) && !pend) state_next = plst_pkg::S_FINISH;
      end
      plst_pkg::S_READ: state_next = plst_pkg::S_FINISH;
      plst_pkg::S_FIND: begin
        if (pend && rdata == val_q) begin
          state_next = plst_pkg::S_FINISH;
        end else if (!(ptr < count) && !pend) begin
          state_next = plst_pkg::S_FINISH;
        end
      end
      plst_pkg::S_FINISH: begin
        if (!rsp.valid || rsp.ready) state_next = plst_pkg::S_IDLE;
      end
      default: state_next = plst_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_next     = count;
    ptr_next       = ptr;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    pos_next       = pos_q;
    val_next       = val_q;
    ok_next        = ok_q;
    rd_next        = rd_q;
    found_next     = found_q;
    mem_re         = 1'b0;
    mem_ra         = to_addr(ptr);
    mem_we         = 1'b0;
    mem_wa         = to_addr(pend_addr);
    mem_wd         = rdata;
    rsp_load       = 1'b0;
    case (state)
      plst_pkg::S_IDLE: begin
        if (req_fire) begin
          pos_next   = req.position;
          val_next   = val_ext[DATA_WIDTH-1:0];
          ok_next    = 1'b0;
          rd_next    = '0;
          found_next = plst_pkg::FOUND_NONE;
          pend_next  = 1'b0;
          case (req.cmd)
            plst_pkg::CMD_INSERT: ptr_next = count;
            plst_pkg::CMD_ERASE:  ptr_next = req.position + 7'd1;
            plst_pkg::CMD_READ: begin
              mem_re = (req.position < count);
              mem_ra = to_addr(req.position);
            end
            plst_pkg::CMD_FIND: begin
              ptr_next = '0;
              ok_next  = 1'b1;
            end
            plst_pkg::CMD_CLEAR: begin
              count_next = '0;
              ok_next    = 1'b1;
            end
            default: ok_next = 1'b0;
          endcase
        end
      end
      // shift up from the top, one entry per cycle, then drop the new word in
      plst_pkg::S_INSERT: begin
        mem_we = pend;
        if (ptr > pos_q) begin
          mem_re         = 1'b1;
          mem_ra         = to_addr(ptr - 7'd1);
          pend_next      = 1'b1;
          pend_addr_next = ptr;
          ptr_next       = ptr - 7'd1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we     = 1'b1;
            mem_wa     = to_addr(pos_q);
            mem_wd     = val_q;
            count_next = count + 7'd1;
            ok_next    = 1'b1;
          end
        end
      end
      // shift down from the erased slot to the end
      plst_pkg::S_ERASE: begin
        mem_we = pend;
        if (ptr < count) begin
          mem_re         = 1'b1;
          mem_ra         = to_addr(ptr);
          pend_next      = 1'b1;
          pend_addr_next = ptr - 7'd1;
          ptr_next       = ptr + 7'd1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - 7'd1;
            ok_next    = 1'b1;
          end
        end
      end
      plst_pkg::S_READ: begin
        rd_next = rdata_ext[plst_pkg::VAL_W-1:0];
        ok_next = 1'b1;
      end
      // linear search, compare comes in the cycle after the read
      plst_pkg::S_FIND: begin
        if (pend && rdata == val_q) begin
          found_next = pend_addr;
          pend_next  = 1'b0;
        end else if (ptr < count) begin
          mem_re         = 1'b1;
          mem_ra         = to_addr(ptr);
          pend_next      = 1'b1;
          pend_addr_next = ptr;
          ptr_next       = ptr + 7'd1;
        end else begin
          pend_next = 1'b0;
        end
      end
      plst_pkg::S_FINISH: begin
        rsp_load = !rsp.valid || rsp.ready;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plst_pkg::S_IDLE;
      count     <= '0;
      cap       <= plst_pkg::CAP_RESET;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (cfg.valid && cfg.ready) cap <= cfg.capacity_limit;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    pos_q     <= pos_next;
    val_q     <= val_next;
    ok_q      <= ok_next;
    rd_q      <= rd_next;
    found_q   <= found_next;
    if (rsp_load) begin
      rsp.ok          <= ok_q;
      rsp.read_value  <= rd_q;
      rsp.found_index <= found_q;
      rsp.entry_count <= count;
      rsp.empty_flag  <= (count == '0);
      rsp.full_flag   <= (count >= eff_lim);
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[mem_ra];
  end

  // the shift never reads the slot it writes in the same cycle
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("memory read and write hit the same entry");

  // the count never passes the storage bound
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LIM_C)
    else $error("entry count beyond storage");

  // count only moves while a command is in flight
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == plst_pkg::S_IDLE && !req_fire) |=> $stable(count))
    else $error("entry count changed with no command");

  // an insert in progress always had room
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == plst_pkg::S_INSERT) |-> (count < eff_lim))
    else $error("insert running on a full list");

endmodule

>>> sim/tb_positional_list_store.sv
// tb_positional_list_store: self-checking bench for the positional list store
// drives commands and capacity writes, predicts every response, checks each transfer
// depends on plst_pkg, the interfaces in plst_ifs and positional_list_store
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = plst_pkg::DEPTH_DEF;

  // one response as the bench expects it
  typedef struct packed {
    logic                              ok;
    logic [plst_pkg::VAL_W-1:0]        read_value;
    logic signed [plst_pkg::IDX_W-1:0] found_index;
    logic [plst_pkg::CNT_W-1:0]        entry_count;
    logic                              empty_flag;
    logic                              full_flag;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst;

  plst_cmd_if cmd_ch ();
  plst_rsp_if rsp_ch ();
  plst_cfg_if cap_ch ();

  positional_list_store dut (
    .clk (clk),
    .rst (rst),
    .req (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cap_ch)
  );

  // shadow copy of the list and its limit
  logic [plst_pkg::VAL_W-1:0] list_words [LIST_DEPTH];
  int                         list_len = 0;
  logic [plst_pkg::CAP_W-1:0] cap_limit = plst_pkg::CAP_RESET;

  list_rsp_t awaited_rsps [$];
  int        error_total = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;

  always #2 clk = ~clk;

  // expected response of one command, updates the shadow list
  function automatic list_rsp_t apply_list_cmd(logic [plst_pkg::CMD_W-1:0] op,
                                               logic [plst_pkg::POS_W-1:0] pos,
                                               logic [plst_pkg::VAL_W-1:0] word);
    list_rsp_t r;
    int        lim;
    int        i;
    r = '0;
    r.found_index = plst_pkg::FOUND_NONE;
    lim = (cap_limit < LIST_DEPTH) ? int'(cap_limit) : LIST_DEPTH;
    case (op)
      plst_pkg::CMD_INSERT: begin
        if (list_len < lim && int'(pos) <= list_len) begin
          for (i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_len++;
          r.ok = 1'b1;
        end
      end
      plst_pkg::CMD_ERASE: begin
        if (int'(pos) < list_len) begin
          for (i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      plst_pkg::CMD_READ: begin
        if (int'(pos) < list_len) begin
          r.read_value = list_words[pos];
          r.ok = 1'b1;
        end
      end
      plst_pkg::CMD_FIND: begin
        r.ok = 1'b1;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == word) begin
            r.found_index = plst_pkg::IDX_W'(i);
            break;
          end
        end
      end
      plst_pkg::CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = plst_pkg::CNT_W'(list_len);
    r.empty_flag  = (list_len == 0);
    r.full_flag   = (list_len >= lim);
    return r;
  endfunction

  // random slot inside the current list, 0 when empty
  function automatic logic [plst_pkg::POS_W-1:0] pick_slot();
    return (list_len != 0) ? plst_pkg::POS_W'($urandom_range(list_len - 1)) : '0;
  endfunction

  // data word, often from a small pool so find hits and duplicates occur
  function automatic logic [plst_pkg::VAL_W-1:0] pick_word();
    return ($urandom_range(99) < 40) ? plst_pkg::VAL_W'($urandom_range(15))
                                     : plst_pkg::VAL_W'($urandom);
  endfunction

  task automatic check_field(string field, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      error_total++;
    end
  endtask

  // response sink ready, idles at random
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // check each response transfer against the oldest expectation
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsps.size() == 0) begin
        $error("response transfer with no command outstanding");
        error_total++;
      end else begin
        want = awaited_rsps.pop_front();
        check_field("ok", want.ok, rsp_ch.ok);
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("found_index", $signed(want.found_index), $signed(rsp_ch.found_index));
        check_field("entry_count", want.entry_count, rsp_ch.entry_count);
        check_field("empty_flag", want.empty_flag, rsp_ch.empty_flag);
        check_field("full_flag", want.full_flag, rsp_ch.full_flag);
      end
    end
  end

  // one command transfer; entered and left at a falling edge, valid stays high
  task automatic send_cmd(logic [plst_pkg::CMD_W-1:0] op, logic [plst_pkg::POS_W-1:0] pos,
                          logic [plst_pkg::VAL_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= op;
    cmd_ch.position <= pos;
    cmd_ch.value    <= word;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    awaited_rsps.push_back(apply_list_cmd(op, pos, word));
    @(negedge clk);
  endtask

  // stop sending and wait until every response has come back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited_rsps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // capacity write, only with the block idle
  task automatic write_cap(logic [plst_pkg::CAP_W-1:0] lim);
    drain_results();
    cap_ch.valid          <= 1'b1;
    cap_ch.capacity_limit <= lim;
    @(posedge clk);
    while (!cap_ch.ready) @(posedge clk);
    cap_limit = lim;
    @(negedge clk);
    cap_ch.valid <= 1'b0;
  endtask

  // every command, field extremes and the refusal cases at the reset limit
  task automatic test_basic_ops();
    send_cmd(plst_pkg::CMD_READ, 0, 0);
    send_cmd(plst_pkg::CMD_ERASE, 0, 0);
    send_cmd(plst_pkg::CMD_FIND, 0, 0);
    send_cmd(plst_pkg::CMD_INSERT, 1, 32'h1111_1111);
    send_cmd(plst_pkg::CMD_INSERT, 0, '0);
    send_cmd(plst_pkg::CMD_INSERT, 1, '1);
    send_cmd(plst_pkg::CMD_INSERT, 1, 32'hA5A5_5A5A);
    send_cmd(plst_pkg::CMD_INSERT, 0, '1);
    for (int p = 0; p <= 4; p++) send_cmd(plst_pkg::CMD_READ, plst_pkg::POS_W'(p), 0);
    send_cmd(plst_pkg::CMD_FIND, 0, '1);
    send_cmd(plst_pkg::CMD_FIND, 0, 32'h1234_5678);
    send_cmd(plst_pkg::CMD_ERASE, 4, 0);
    send_cmd(plst_pkg::CMD_ERASE, '1, 0);
    send_cmd(plst_pkg::CMD_INSERT, '1, 32'h5A5A_A5A5);
    send_cmd(plst_pkg::CMD_ERASE, 1, 0);
    send_cmd(plst_pkg::CMD_FIND, 0, '0);
    // unused command codes leave the list alone
    for (int c = int'(plst_pkg::CMD_CLEAR) + 1; c < 2**plst_pkg::CMD_W; c++)
      send_cmd(plst_pkg::CMD_W'(c), 0, $urandom);
    send_cmd(plst_pkg::CMD_CLEAR, 0, 0);
    send_cmd(plst_pkg::CMD_READ, 0, 0);
  endtask

  // limits of one, zero and above the store depth
  task automatic test_full_and_limits();
    write_cap(1);
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_INSERT, 1, $urandom);
    send_cmd(plst_pkg::CMD_CLEAR, 0, 0);
    // zero limit: empty and full at once
    write_cap(0);
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_FIND, 0, 0);
    // limit past the depth: the store depth caps the list
    write_cap('1);
    for (int k = 0; k < LIST_DEPTH; k++)
      send_cmd(plst_pkg::CMD_INSERT, plst_pkg::POS_W'($urandom_range(list_len)), pick_word());
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_INSERT, plst_pkg::POS_W'(LIST_DEPTH), $urandom);
    send_cmd(plst_pkg::CMD_READ, plst_pkg::POS_W'(LIST_DEPTH - 1), 0);
    send_cmd(plst_pkg::CMD_READ, plst_pkg::POS_W'(LIST_DEPTH), 0);
    send_cmd(plst_pkg::CMD_FIND, 0, list_words[LIST_DEPTH - 1]);
    send_cmd(plst_pkg::CMD_ERASE, plst_pkg::POS_W'(LIST_DEPTH - 1), 0);
    send_cmd(plst_pkg::CMD_ERASE, 0, 0);
    send_cmd(plst_pkg::CMD_CLEAR, 0, 0);
  endtask

  // limit lowered under the current count
  task automatic test_limit_below_count();
    write_cap(plst_pkg::CAP_W'(LIST_DEPTH));
    for (int k = 0; k < 10; k++)
      send_cmd(plst_pkg::CMD_INSERT, plst_pkg::POS_W'(list_len), pick_word());
    write_cap(3);
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_READ, 9, 0);
    for (int k = 0; k < 8; k++) send_cmd(plst_pkg::CMD_ERASE, 0, 0);
    send_cmd(plst_pkg::CMD_INSERT, 2, $urandom);
    send_cmd(plst_pkg::CMD_INSERT, 0, $urandom);
    send_cmd(plst_pkg::CMD_CLEAR, 0, 0);
  endtask

  // one random command: mostly in range, some noise
  task automatic send_random_item(int ins_w);
    int                         roll;
    logic [plst_pkg::CMD_W-1:0] op;
    logic [plst_pkg::POS_W-1:0] pos;
    logic [plst_pkg::VAL_W-1:0] word;
    roll = $urandom_range(99);
    word = pick_word();
    pos  = '0;
    if (roll < 8) begin
      op   = plst_pkg::CMD_W'($urandom_range(2**plst_pkg::CMD_W - 1));
      pos  = plst_pkg::POS_W'($urandom_range(2**plst_pkg::POS_W - 1));
      word = $urandom;
    end else begin
      roll = $urandom_range(99);
      if (roll < ins_w) begin
        op  = plst_pkg::CMD_INSERT;
        pos = plst_pkg::POS_W'($urandom_range(list_len));
      end else if (roll < ins_w + 20) begin
        op  = plst_pkg::CMD_ERASE;
        pos = pick_slot();
      end else if (roll < ins_w + 40) begin
        op  = plst_pkg::CMD_READ;
        pos = pick_slot();
      end else if (roll < 98) begin
        op = plst_pkg::CMD_FIND;
        if (list_len != 0 && $urandom_range(1)) word = list_words[pick_slot()];
      end else begin
        op = plst_pkg::CMD_CLEAR;
      end
    end
    send_cmd(op, pos, word);
  endtask

  // random traffic in segments, each with its own limit; the idle pattern changes every two segments
  task automatic test_random_traffic(int n_items);
    logic [plst_pkg::CAP_W-1:0] seg_caps [6];
    int                         per_seg;
    seg_caps = '{'1, 8, 2, plst_pkg::CAP_W'(LIST_DEPTH), 33,
                 plst_pkg::CAP_W'($urandom_range(1, 2**plst_pkg::CAP_W - 1))};
    per_seg  = n_items / 6;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0:       begin src_idle_pct = 13; sink_idle_pct = 74; end
        1:       begin src_idle_pct = 74; sink_idle_pct = 13; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      write_cap(seg_caps[seg]);
      for (int k = 0; k < per_seg; k++) begin
        send_random_item(30 + 5 * seg);
        // occasional full stop so the list is idle mid-stream
        if (k == per_seg / 2) drain_results();
      end
    end
  endtask

  // test sequence
  initial begin
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.cmd            = '0;
    cmd_ch.position       = '0;
    cmd_ch.value          = '0;
    cap_ch.valid          = 1'b0;
    cap_ch.capacity_limit = '0;
    src_idle_pct          = 13;
    sink_idle_pct         = 74;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_ops();
    test_full_and_limits();
    test_limit_below_count();
    test_random_traffic(1700);

    drain_results();
    repeat (80) @(negedge clk);
    if (error_total == 0) begin
      $display("tb_positional_list_store: PASS");
    end else begin
      $display("tb_positional_list_store: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #4ms;
    $display("tb_positional_list_store: FAIL");
    $finish;
  end

endmodule
